// ===== sv/bmpfb_pkg.sv =====
// Shared types, constants and helpers for the BMP pixel to framebuffer converter.
// Used by the top level, the channel divider and the port checker; no dependencies.
package bmpfb_pkg;

  // Color channels in the bitfield path
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // Pipeline shape: mask decode, shift, scale, one quotient bit per stage, pack
  localparam int unsigned PRE_STAGES  = 3;
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned POST_STAGES = 2;
  localparam int unsigned PIPE_DEPTH  = PRE_STAGES + DIV_STEPS + POST_STAGES;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_OUTPUT_FORMAT = 3'd1,
    REG_RED_MASK      = 3'd2,
    REG_GREEN_MASK    = 3'd3,
    REG_BLUE_MASK     = 3'd4
  } cfg_reg_e;

  // Source format codes (code 3 behaves as plain BGRX)
  localparam logic [1:0] SRC_BGR24    = 2'd0;
  localparam logic [1:0] SRC_BGRX32   = 2'd1;
  localparam logic [1:0] SRC_BITFIELD = 2'd2;

  // Output format codes
  localparam logic OUT_XRGB8888 = 1'b0;
  localparam logic OUT_RGB565   = 1'b1;

  // RGB565 reduction factors
  localparam logic [13:0] SCALE5 = 14'd31;
  localparam logic [13:0] SCALE6 = 14'd63;

  // One restoring-division stage
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] rem;
    logic [7:0]  quo;
  } div_stage_t;

  // floor(y / 255) for y below 16320, where the quotient fits in six bits
  function automatic logic [5:0] div255(input logic [13:0] y);
    logic [14:0] t;
    t = {1'b0, y} + {9'b0, y[13:8]} + 15'd1;
    return t[13:8];
  endfunction

endpackage

// ===== sv/bmp_pixel_to_framebuffer_format.sv =====
// Top level of the BMP source pixel to framebuffer pixel converter.
// Depends on bmpfb_pkg and bmpfb_div (three instances, one per channel).
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one raw source pixel per item;
//   output channel out_valid_o/out_ready_i carries one framebuffer pixel per item.
//   The configuration channel cfg_valid_i/cfg_ready_o writes source format,
//   output format and the three channel masks by index; it is always ready.
//   It is to be written only while no item is in flight; the block does not enforce this.
//   Throughput: one item per clock while the skid entry is empty. Every format
//   passes through the same stages: the bitfield scaling divider, 32 stages of
//   one quotient bit each, plus three stages of mask decode, shift and scale and
//   two stages of color selection and packing.
//   Reset clears all item valid bits and loads the registers to 32-bit
//   BGRX in, XRGB8888 out, all masks zero.
//   When the receiver stalls, a one-entry skid register takes the oldest result
//   and the pipeline keeps moving for that cycle; after that the whole pipeline
//   holds and in_ready_o drops until the skid entry is taken.
module bmp_pixel_to_framebuffer_format (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bmpfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  // source pixels
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [31:0]                        source_pixel_i,
  // framebuffer pixels
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        frame_pixel_o
);

  // Configuration registers
  logic [1:0]  source_format_q;
  logic        output_format_q;
  logic [31:0] red_mask_q;
  logic [31:0] green_mask_q;
  logic [31:0] blue_mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_format_q <= bmpfb_pkg::SRC_BGRX32;
      output_format_q <= bmpfb_pkg::OUT_XRGB8888;
      red_mask_q      <= 32'd0;
      green_mask_q    <= 32'd0;
      blue_mask_q     <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bmpfb_pkg::REG_SOURCE_FORMAT: source_format_q <= cfg_data_i[1:0];
        bmpfb_pkg::REG_OUTPUT_FORMAT: output_format_q <= cfg_data_i[0];
        bmpfb_pkg::REG_RED_MASK:      red_mask_q      <= cfg_data_i;
        bmpfb_pkg::REG_GREEN_MASK:    green_mask_q    <= cfg_data_i;
        bmpfb_pkg::REG_BLUE_MASK:     blue_mask_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] mask [bmpfb_pkg::NUM_CH];
  assign mask[bmpfb_pkg::CH_RED]   = red_mask_q;
  assign mask[bmpfb_pkg::CH_GREEN] = green_mask_q;
  assign mask[bmpfb_pkg::CH_BLUE]  = blue_mask_q;

  // Flow control: everything moves unless the skid entry is occupied
  logic                            adv;
  logic [bmpfb_pkg::PIPE_DEPTH-1:0] v_q;
  logic                            skid_v_q;
  logic                            skid_v_d;
  logic [31:0]                     skid_data_q;

  assign adv        = ~skid_v_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[bmpfb_pkg::PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // Stage 1: lowest set bit, smeared mask and masked pixel per channel
  logic [31:0] s1_masked_d [bmpfb_pkg::NUM_CH];
  logic [31:0] s1_smear_d  [bmpfb_pkg::NUM_CH];
  logic [4:0]  s1_lsb_d    [bmpfb_pkg::NUM_CH];
  logic        s1_zero_d   [bmpfb_pkg::NUM_CH];
  logic [31:0] s1_masked_q [bmpfb_pkg::NUM_CH];
  logic [31:0] s1_smear_q  [bmpfb_pkg::NUM_CH];
  logic [4:0]  s1_lsb_q    [bmpfb_pkg::NUM_CH];
  logic        s1_zero_q   [bmpfb_pkg::NUM_CH];
  logic [23:0] s1_px_q;

  always_comb begin
    for (int c = 0; c < bmpfb_pkg::NUM_CH; c++) begin
      s1_lsb_d[c] = 5'd0;
      for (int i = 31; i >= 0; i--) begin
        if (mask[c][i]) s1_lsb_d[c] = 5'(i);
      end
      // ones from the top set bit down to bit 0
      s1_smear_d[c]  = mask[c] | (mask[c] >> 1);
      s1_smear_d[c]  = s1_smear_d[c] | (s1_smear_d[c] >> 2);
      s1_smear_d[c]  = s1_smear_d[c] | (s1_smear_d[c] >> 4);
      s1_smear_d[c]  = s1_smear_d[c] | (s1_smear_d[c] >> 8);
      s1_smear_d[c]  = s1_smear_d[c] | (s1_smear_d[c] >> 16);
      s1_masked_d[c] = source_pixel_i & mask[c];
      s1_zero_d[c]   = (mask[c] == 32'd0);
    end
  end

  // Stage 2: field aligned to bit 0, divisor 2^span-1
  logic [31:0] s2_field_d [bmpfb_pkg::NUM_CH];
  logic [31:0] s2_den_d   [bmpfb_pkg::NUM_CH];
  logic [31:0] s2_field_q [bmpfb_pkg::NUM_CH];
  logic [31:0] s2_den_q   [bmpfb_pkg::NUM_CH];
  logic [23:0] s2_px_q;

  always_comb begin
    for (int c = 0; c < bmpfb_pkg::NUM_CH; c++) begin
      s2_field_d[c] = s1_masked_q[c] >> s1_lsb_q[c];
      // zero mask: numerator is zero, any nonzero divisor gives 0
      s2_den_d[c]   = s1_zero_q[c] ? 32'hFFFF_FFFF : (s1_smear_q[c] >> s1_lsb_q[c]);
    end
  end

  // Stage 3: field * 255, wrapping at 32 bits
  logic [31:0] s3_num_d [bmpfb_pkg::NUM_CH];
  logic [31:0] s3_num_q [bmpfb_pkg::NUM_CH];
  logic [31:0] s3_den_q [bmpfb_pkg::NUM_CH];
  logic [23:0] s3_px_q;

  always_comb begin
    for (int c = 0; c < bmpfb_pkg::NUM_CH; c++) begin
      s3_num_d[c] = {s2_field_q[c][23:0], 8'd0} - s2_field_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_masked_q <= s1_masked_d;
      s1_smear_q  <= s1_smear_d;
      s1_lsb_q    <= s1_lsb_d;
      s1_zero_q   <= s1_zero_d;
      s1_px_q     <= source_pixel_i[23:0];
      s2_field_q  <= s2_field_d;
      s2_den_q    <= s2_den_d;
      s2_px_q     <= s1_px_q;
      s3_num_q    <= s3_num_d;
      s3_den_q    <= s2_den_q;
      s3_px_q     <= s2_px_q;
    end
  end

  // Division stages, one divider per channel, raw bytes delayed alongside
  logic [7:0]  quo [bmpfb_pkg::NUM_CH];
  logic [23:0] px_dly_q [bmpfb_pkg::DIV_STEPS];

  for (genvar c = 0; c < bmpfb_pkg::NUM_CH; c++) begin : g_div
    bmpfb_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (s3_num_q[c]),
      .den_i (s3_den_q[c]),
      .quo_o (quo[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_dly_q[0] <= s3_px_q;
      for (int k = 1; k < bmpfb_pkg::DIV_STEPS; k++) begin
        px_dly_q[k] <= px_dly_q[k-1];
      end
    end
  end

  // Post stage 1: pick channel source, form RGB565 products
  logic [23:0] px_last;
  logic        use_masks;
  logic [7:0]  p1_r_d, p1_g_d, p1_b_d;
  logic [7:0]  p1_r_q, p1_g_q, p1_b_q;
  logic [13:0] p1_pr_q, p1_pg_q, p1_pb_q;

  assign px_last   = px_dly_q[bmpfb_pkg::DIV_STEPS-1];
  assign use_masks = (source_format_q == bmpfb_pkg::SRC_BITFIELD);

  always_comb begin
    if (use_masks) begin
      p1_r_d = quo[bmpfb_pkg::CH_RED];
      p1_g_d = quo[bmpfb_pkg::CH_GREEN];
      p1_b_d = quo[bmpfb_pkg::CH_BLUE];
    end else begin
      p1_r_d = px_last[23:16];
      p1_g_d = px_last[15:8];
      p1_b_d = px_last[7:0];
    end
  end

  // Post stage 2: scale down and pack
  logic [5:0]  r5_full, g6_full, b5_full;
  logic [31:0] word_d;
  logic [31:0] word_q;

  always_comb begin
    r5_full = bmpfb_pkg::div255(p1_pr_q);
    g6_full = bmpfb_pkg::div255(p1_pg_q);
    b5_full = bmpfb_pkg::div255(p1_pb_q);
    if (output_format_q == bmpfb_pkg::OUT_RGB565) begin
      word_d = {16'd0, r5_full[4:0], g6_full, b5_full[4:0]};
    end else begin
      word_d = {8'd0, p1_r_q, p1_g_q, p1_b_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_r_q  <= p1_r_d;
      p1_g_q  <= p1_g_d;
      p1_b_q  <= p1_b_d;
      p1_pr_q <= {6'd0, p1_r_d} * bmpfb_pkg::SCALE5;
      p1_pg_q <= {6'd0, p1_g_d} * bmpfb_pkg::SCALE6;
      p1_pb_q <= {6'd0, p1_b_d} * bmpfb_pkg::SCALE5;
      word_q  <= word_d;
    end
  end

  // Skid entry: catches the last stage when the receiver stalls
  logic last_v;
  assign last_v = v_q[bmpfb_pkg::PIPE_DEPTH-1];

  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q && out_ready_i) begin
      skid_v_d = 1'b0;
    end else if (adv && last_v && !out_ready_i) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_v && !out_ready_i) begin
      skid_data_q <= word_q;
    end
  end

  assign out_valid_o   = skid_v_q | last_v;
  assign frame_pixel_o = skid_v_q ? skid_data_q : word_q;

endmodule

// ===== sv/bmpfb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, low 8 quotient bits out.
// Depends on bmpfb_pkg (div_stage_t, DIV_STEPS).
module bmpfb_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [7:0]  quo_o
);

  bmpfb_pkg::div_stage_t src  [bmpfb_pkg::DIV_STEPS];
  bmpfb_pkg::div_stage_t st_d [bmpfb_pkg::DIV_STEPS];
  bmpfb_pkg::div_stage_t st_q [bmpfb_pkg::DIV_STEPS];

  // Stage inputs: the first stage starts from a zero remainder
  assign src[0] = '{num: num_i, den: den_i, rem: 32'd0, quo: 8'd0};

  for (genvar k = 1; k < bmpfb_pkg::DIV_STEPS; k++) begin : g_src
    assign src[k] = st_q[k-1];
  end

  // One trial subtract per stage; borrow out says the divisor did not fit
  for (genvar k = 0; k < bmpfb_pkg::DIV_STEPS; k++) begin : g_step
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        fit;

    always_comb begin
      rem_sh      = {src[k].rem, src[k].num[31]};
      diff        = rem_sh - {1'b0, src[k].den};
      fit         = ~diff[32];
      st_d[k].num = {src[k].num[30:0], 1'b0};
      st_d[k].den = src[k].den;
      st_d[k].rem = fit ? diff[31:0] : rem_sh[31:0];
      st_d[k].quo = {src[k].quo[6:0], fit};
    end
  end

  // Stage registers advance together with the rest of the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign quo_o = st_q[bmpfb_pkg::DIV_STEPS-1].quo;

endmodule

// ===== sv/bmpfb_checker.sv =====
// Port-level checker for the BMP pixel to framebuffer converter, bound to the top level.
// Depends on bmpfb_pkg (pipeline depth, register indexes, format codes).
module bmpfb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [bmpfb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [31:0]                     cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [31:0]                     frame_pixel_o
);

  localparam int unsigned CntW = $clog2(bmpfb_pkg::PIPE_DEPTH + 2);

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] cnt_q;
  logic            fmt565_q;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // Items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Shadow of the output format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt565_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o &&
                 cfg_index_i == bmpfb_pkg::REG_OUTPUT_FORMAT) begin
      fmt565_q <= (cfg_data_i[0] == bmpfb_pkg::OUT_RGB565);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_pixel_o))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result offered with no item in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bmpfb_pkg::PIPE_DEPTH + 1))
    else $error("more items in flight than pipeline and skid can hold");

  a_top_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_pixel_o[31:24] == 8'h00)
    else $error("pad byte of result not zero");

  a_rgb565: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fmt565_q |-> frame_pixel_o[31:16] == 16'h0000)
    else $error("RGB565 result has upper half set");

endmodule

bind bmp_pixel_to_framebuffer_format bmpfb_checker u_bmpfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .frame_pixel_o (frame_pixel_o)
);

// ===== tb/bmp_pixel_to_framebuffer_format_tb.sv =====
// Self-checking testbench for bmp_pixel_to_framebuffer_format: directed pixel table, then
// random pixels under random register settings, checked against an in-bench color converter.
// Depends on bmpfb_pkg and the converter RTL only.
module bmp_pixel_to_framebuffer_format_tb;

  // Unused source format code, decoded as plain BGRX
  localparam logic [1:0] SRC_SPARE = 2'd3;

  localparam int NUM_DIR         = 23;
  localparam int NUM_SETTINGS    = 24;
  localparam int PIXELS_PER_SET  = 50;
  localparam int CYCLE_LIMIT     = 200_000;

  // DUT ports
  logic                            clk_i;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_valid_i    = 1'b0;
  logic                            cfg_ready_o;
  logic [bmpfb_pkg::CFG_IDX_W-1:0] cfg_index_i    = bmpfb_pkg::REG_SOURCE_FORMAT;
  logic [31:0]                     cfg_data_i     = 32'h0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic [31:0]                     source_pixel_i = 32'h0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b1;
  logic [31:0]                     frame_pixel_o;

  bmp_pixel_to_framebuffer_format dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .source_pixel_i (source_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_pixel_o  (frame_pixel_o)
  );

  // Shadow of the converter registers, at reset values
  logic [1:0]  cur_src = bmpfb_pkg::SRC_BGRX32;
  logic        cur_out = bmpfb_pkg::OUT_XRGB8888;
  logic [31:0] cur_mask [bmpfb_pkg::NUM_CH] = '{32'h0, 32'h0, 32'h0};

  // Frame pixels still owed by the DUT, oldest first
  typedef struct {
    logic [31:0] src_px;
    logic [31:0] frame;
  } due_pixel_t;
  due_pixel_t frame_due [$];

  int  pixels_sent    = 0;
  int  pixels_checked = 0;
  int  mismatches     = 0;
  int  settings_used  = 0;
  int  cycle_count    = 0;
  int  rx_hold        = 0;
  bit  tx_steady      = 1'b0;
  bit  rx_steady      = 1'b0;

  // Directed rows: register setting, pixel, and a typed-in answer where obvious
  typedef struct packed {
    logic [1:0]  src;
    logic        out;
    logic [31:0] rmask;
    logic [31:0] gmask;
    logic [31:0] bmask;
    logic [31:0] px;
    logic        fixed;
    logic [31:0] want;
  } dir_row_t;

  dir_row_t dir_rows [NUM_DIR] = '{
    // reset setting, extremes
    '{bmpfb_pkg::SRC_BGRX32, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF},
    '{bmpfb_pkg::SRC_BGRX32, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'h0000_0000, 1'b1, 32'h0000_0000},
    '{bmpfb_pkg::SRC_BGRX32, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'hAA12_3456, 1'b1, 32'h0012_3456},
    // 24-bit: top byte ignored
    '{bmpfb_pkg::SRC_BGR24, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'hFF80_8080, 1'b1, 32'h0080_8080},
    '{bmpfb_pkg::SRC_BGR24, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'h00FF_FFFF, 1'b1, 32'h00FF_FFFF},
    // spare selector acts as BGRX
    '{SRC_SPARE, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'h12AB_CDEF, 1'b1, 32'h00AB_CDEF},
    // RGB565 output
    '{bmpfb_pkg::SRC_BGRX32, bmpfb_pkg::OUT_RGB565, 32'h0, 32'h0, 32'h0,
      32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF},
    '{bmpfb_pkg::SRC_BGRX32, bmpfb_pkg::OUT_RGB565, 32'h0, 32'h0, 32'h0,
      32'h0000_0000, 1'b1, 32'h0000_0000},
    '{bmpfb_pkg::SRC_BGRX32, bmpfb_pkg::OUT_RGB565, 32'h0, 32'h0, 32'h0,
      32'h0080_8080, 1'b0, 32'h0},
    '{bmpfb_pkg::SRC_BGR24, bmpfb_pkg::OUT_RGB565, 32'h0, 32'h0, 32'h0,
      32'h7F3A_19C4, 1'b0, 32'h0},
    // bitfield, byte masks pass straight through
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h00FF_0000, 32'h0000_FF00,
      32'h0000_00FF, 32'h1234_5678, 1'b1, 32'h0034_5678},
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h00FF_0000, 32'h0000_FF00,
      32'h0000_00FF, 32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF},
    // zero masks give black
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h0, 32'h0, 32'h0,
      32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // full-width masks, product wraps
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
    // 565-style masks
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h0000_F800, 32'h0000_07E0,
      32'h0000_001F, 32'h0000_FFFF, 1'b1, 32'h00FF_FFFF},
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h0000_F800, 32'h0000_07E0,
      32'h0000_001F, 32'h0000_8410, 1'b0, 32'h0},
    // 25-bit field, product wraps below the division
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h01FF_FFFF, 32'h0, 32'h0,
      32'h01FF_FFFF, 1'b0, 32'h0},
    // one-bit masks at both ends of the word
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h8000_0000, 32'h0000_0001,
      32'h0, 32'h8000_0001, 1'b1, 32'h00FF_FF00},
    // masks with holes
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_XRGB8888, 32'h00F0_000F, 32'h0000_FF00,
      32'hC000_0003, 32'hA5F3_C30F, 1'b0, 32'h0},
    // bitfield into RGB565
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_RGB565, 32'h00FF_0000, 32'h0000_FF00,
      32'h0000_00FF, 32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF},
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_RGB565, 32'h00FF_0000, 32'h0000_FF00,
      32'h0000_00FF, 32'h0010_2030, 1'b0, 32'h0},
    '{bmpfb_pkg::SRC_BITFIELD, bmpfb_pkg::OUT_RGB565, 32'hFFFF_FFFF, 32'h3FFF_FFFF,
      32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0, 32'h0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Scale one masked channel to 8 bits; product wraps at 32 bits
  function automatic logic [7:0] scale_channel(input logic [31:0] px, input logic [31:0] mask);
    int          lo;
    int          hi;
    logic [31:0] field;
    logic [31:0] prod;
    logic [31:0] full;
    logic [31:0] quot;
    if (mask == 32'h0) return 8'h00;
    lo = 0;
    while (!mask[lo]) lo++;
    hi = 31;
    while (!mask[hi]) hi--;
    field = (px & mask) >> lo;
    prod  = field * 32'd255;
    full  = (hi - lo + 1 == 32) ? 32'hFFFF_FFFF : ((32'd1 << (hi - lo + 1)) - 32'd1);
    quot  = prod / full;
    return quot[7:0];
  endfunction

  // Expected frame pixel under the current register shadow
  function automatic logic [31:0] convert_pixel(input logic [31:0] px);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    int unsigned r5;
    int unsigned g6;
    int unsigned b5;
    if (cur_src == bmpfb_pkg::SRC_BITFIELD) begin
      r = scale_channel(px, cur_mask[bmpfb_pkg::CH_RED]);
      g = scale_channel(px, cur_mask[bmpfb_pkg::CH_GREEN]);
      b = scale_channel(px, cur_mask[bmpfb_pkg::CH_BLUE]);
    end else begin
      b = px[7:0];
      g = px[15:8];
      r = px[23:16];
    end
    if (cur_out == bmpfb_pkg::OUT_RGB565) begin
      r5 = (int'(r) * 31) / 255;
      g6 = (int'(g) * 63) / 255;
      b5 = (int'(b) * 31) / 255;
      return {16'h0000, r5[4:0], g6[5:0], b5[4:0]};
    end
    return {8'h00, r, g, b};
  endfunction

  // Mask mix: zero, full, single bit, contiguous run, byte lane, anything
  function automatic logic [31:0] random_mask();
    int unsigned w;
    int unsigned lo;
    logic [32:0] ones;
    w    = $urandom_range(1, 32);
    lo   = $urandom_range(0, 32 - w);
    ones = (33'd1 << w) - 33'd1;
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      6: return $urandom();
      7: return 32'h0000_00FF << (8 * $urandom_range(0, 3));
      default: return ones[31:0] << lo;
    endcase
  endfunction

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(0, 15))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return cur_mask[$urandom_range(0, bmpfb_pkg::NUM_CH - 1)];
      3: return ~cur_mask[$urandom_range(0, bmpfb_pkg::NUM_CH - 1)];
      default: return $urandom();
    endcase
  endfunction

  // Register write; caller lowers cfg_valid_i after the last one
  task automatic write_reg(input bmpfb_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bmpfb_pkg::REG_SOURCE_FORMAT: cur_src                      = val[1:0];
      bmpfb_pkg::REG_OUTPUT_FORMAT: cur_out                      = val[0];
      bmpfb_pkg::REG_RED_MASK:      cur_mask[bmpfb_pkg::CH_RED]   = val;
      bmpfb_pkg::REG_GREEN_MASK:    cur_mask[bmpfb_pkg::CH_GREEN] = val;
      bmpfb_pkg::REG_BLUE_MASK:     cur_mask[bmpfb_pkg::CH_BLUE]  = val;
      default: ;
    endcase
  endtask

  // Stop sending and wait for every owed frame pixel
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (frame_due.size() != 0) @(posedge clk_i);
  endtask

  // Offer one source pixel after a random gap; log what should come out
  task automatic send_pixel(input logic [31:0] px, input logic fixed, input logic [31:0] want);
    int         gap;
    due_pixel_t due;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    source_pixel_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    due.src_px = px;
    due.frame  = fixed ? want : convert_pixel(px);
    frame_due.push_back(due);
    pixels_sent++;
  endtask

  // Output side: check each taken item, stall at random
  always @(posedge clk_i) begin
    due_pixel_t due;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frame_due.size() == 0) begin
          $display("%0t: frame pixel 0x%08h with no item pending", $time, frame_pixel_o);
          mismatches++;
        end else begin
          due = frame_due.pop_front();
          pixels_checked++;
          if (frame_pixel_o !== due.frame) begin
            $display("%0t: source 0x%08h: frame_pixel expected 0x%08h, got 0x%08h",
                     $time, due.src_px, due.frame, frame_pixel_o);
            mismatches++;
          end
        end
        rx_hold = rx_steady ? 0 : $urandom_range(0, 7);
        if (rx_hold != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (rx_hold <= 1) begin
          rx_hold = 0;
          out_ready_i <= 1'b1;
        end else begin
          rx_hold--;
        end
      end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
        // stall while idle too, so a result can land on a low ready
        rx_hold = $urandom_range(1, 7);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t    row;
    logic [1:0]  src;
    logic        out_fmt;
    logic [31:0] rm;
    logic [31:0] gm;
    logic [31:0] bm;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; registers rewritten only where a row changes them
    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_rows[i];
      if (row.src != cur_src || row.out != cur_out ||
          row.rmask != cur_mask[bmpfb_pkg::CH_RED] ||
          row.gmask != cur_mask[bmpfb_pkg::CH_GREEN] ||
          row.bmask != cur_mask[bmpfb_pkg::CH_BLUE]) begin
        wait_drained();
        if (row.src != cur_src)
          write_reg(bmpfb_pkg::REG_SOURCE_FORMAT, {30'd0, row.src});
        if (row.out != cur_out)
          write_reg(bmpfb_pkg::REG_OUTPUT_FORMAT, {31'd0, row.out});
        if (row.rmask != cur_mask[bmpfb_pkg::CH_RED])
          write_reg(bmpfb_pkg::REG_RED_MASK, row.rmask);
        if (row.gmask != cur_mask[bmpfb_pkg::CH_GREEN])
          write_reg(bmpfb_pkg::REG_GREEN_MASK, row.gmask);
        if (row.bmask != cur_mask[bmpfb_pkg::CH_BLUE])
          write_reg(bmpfb_pkg::REG_BLUE_MASK, row.bmask);
        cfg_valid_i <= 1'b0;
        settings_used++;
      end
      send_pixel(row.px, row.fixed, row.want);
    end

    // random settings, bitfield mode favored; every register rewritten each time
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case ($urandom_range(0, 7))
        0:       src = bmpfb_pkg::SRC_BGR24;
        1:       src = bmpfb_pkg::SRC_BGRX32;
        2:       src = SRC_SPARE;
        default: src = bmpfb_pkg::SRC_BITFIELD;
      endcase
      out_fmt = ($urandom_range(0, 1) == 1) ? bmpfb_pkg::OUT_RGB565 : bmpfb_pkg::OUT_XRGB8888;
      rm = random_mask();
      gm = random_mask();
      bm = random_mask();
      wait_drained();
      write_reg(bmpfb_pkg::REG_SOURCE_FORMAT, {30'd0, src});
      write_reg(bmpfb_pkg::REG_OUTPUT_FORMAT, {31'd0, out_fmt});
      write_reg(bmpfb_pkg::REG_RED_MASK, rm);
      write_reg(bmpfb_pkg::REG_GREEN_MASK, gm);
      write_reg(bmpfb_pkg::REG_BLUE_MASK, bm);
      cfg_valid_i <= 1'b0;
      settings_used++;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PIXELS_PER_SET; k++) send_pixel(random_pixel(), 1'b0, 32'h0);
    end

    // drain, then watch for stray output
    wait_drained();
    repeat (bmpfb_pkg::PIPE_DEPTH + 8) @(posedge clk_i);
    $display("Sent %0d source pixels under %0d register settings, checked %0d frame pixels.",
             pixels_sent, settings_used, pixels_checked);
    $display("Formats: BGR24, BGRX, spare code, bitfield masks; XRGB8888 and RGB565 out.");
    if (mismatches == 0 && frame_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
